[rtl/dotrig_pkg.sv]
// Package for the drum onset trigger: field widths, register indexes,
// register reset values and the default envelope window length.
// Used by drum_onset_trigger; depends on nothing else.
package dotrig_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 16;
	localparam int OFFSET_W = 13;
	localparam int MASK_W   = 16;
	localparam int SCALED_W = 19;
	localparam int LEVEL_W  = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_FRAC  = 13;

	localparam int WINDOW_LEN_DEFAULT = 256;

	localparam logic [GAIN_W-1:0]   GAIN_MAX    = 16'd49152;
	localparam logic [GAIN_W-1:0]   GAIN_RESET  = 16'd8192;
	localparam logic [THR_W-1:0]    THR_RESET   = 16'd32768;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 13'd512;
	localparam logic [MASK_W-1:0]   MASK_RESET  = 16'd14000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_GAIN      = 3'd0,
		CFG_LEVEL_THRESHOLD = 3'd1,
		CFG_OFFSET_LENGTH   = 3'd2,
		CFG_MASK_LENGTH     = 3'd3,
		CFG_TRIGGER_ENABLE  = 3'd4
	} cfg_reg_t;

endpackage

[rtl/drum_onset_trigger.sv]
// Drum onset trigger: input register, registered gain multiply, then the
// envelope, run and lockout update into the result register.
// Depends on dotrig_pkg.
//
// An accepted item passes the input and scaled-sample registers into the result.
// Throughput is one item per cycle; the three stages advance together and
// stall only while a result waits on out_ready.
// Reset clears all tracking state and loads the register defaults.
module drum_onset_trigger #(
	parameter int WINDOW_LEN = dotrig_pkg::WINDOW_LEN_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dotrig_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dotrig_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [dotrig_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dotrig_pkg::SCALED_W-1:0] scaled_sample,
	output logic                                  trigger_fire,
	output logic [dotrig_pkg::LEVEL_W-1:0]        trigger_level
);

	localparam int WC_W = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [WC_W-1:0] WC_LAST = WC_W'(WINDOW_LEN - 1);
	localparam int PROD_W = dotrig_pkg::SAMPLE_W + dotrig_pkg::GAIN_W + 1;
	localparam int LVL_W = dotrig_pkg::LEVEL_W;

	// Configuration registers
	logic [dotrig_pkg::GAIN_W-1:0]   gain_q;
	logic [dotrig_pkg::THR_W-1:0]    thr_q;
	logic [dotrig_pkg::OFFSET_W-1:0] offset_q;
	logic [dotrig_pkg::MASK_W-1:0]   mask_q;
	logic                            enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= dotrig_pkg::GAIN_RESET;
			thr_q    <= dotrig_pkg::THR_RESET;
			offset_q <= dotrig_pkg::OFFSET_RESET;
			mask_q   <= dotrig_pkg::MASK_RESET;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dotrig_pkg::CFG_INPUT_GAIN: begin
					gain_q <= (cfg_data > dotrig_pkg::GAIN_MAX) ? dotrig_pkg::GAIN_MAX
						: cfg_data;
				end
				dotrig_pkg::CFG_LEVEL_THRESHOLD: thr_q <= cfg_data;
				dotrig_pkg::CFG_OFFSET_LENGTH: offset_q <= cfg_data[dotrig_pkg::OFFSET_W-1:0];
				dotrig_pkg::CFG_MASK_LENGTH: mask_q <= cfg_data;
				dotrig_pkg::CFG_TRIGGER_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control: all stages move together when the result slot frees.
	logic advance;
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic upd;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = advance;
	assign out_valid = out_valid_q;
	assign upd       = advance && s2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q  <= in_valid;
			s2_valid_q  <= s1_valid_q;
			out_valid_q <= s2_valid_q;
		end
	end

	// Stage 1: input register; stage 2: scaled sample.
	logic signed [dotrig_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [dotrig_pkg::SCALED_W-1:0] scaled_s2;
	logic signed [PROD_W-1:0]               prod;

	assign prod = sample_s1 * $signed({1'b0, gain_q});

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= sample_in;
			scaled_s2 <= prod[dotrig_pkg::GAIN_FRAC +: dotrig_pkg::SCALED_W];
		end
	end

	// Tracking state
	logic [LVL_W-1:0]                window_peak_q, envelope_q, run_peak_q, held_q;
	logic [WC_W-1:0]                 window_count_q;
	logic [dotrig_pkg::OFFSET_W-1:0] run_count_q;
	logic [dotrig_pkg::MASK_W-1:0]   lockout_count_q;
	logic                            lockout_active_q;

	logic [dotrig_pkg::SCALED_W-1:0] abs_val;
	logic [LVL_W-1:0]                mag, window_max, run_max;
	logic [LVL_W-1:0]                window_peak_d, envelope_d, run_peak_d, held_d;
	logic [WC_W-1:0]                 window_count_d;
	logic [dotrig_pkg::OFFSET_W:0]   run_inc;
	logic [dotrig_pkg::OFFSET_W-1:0] run_count_d;
	logic [dotrig_pkg::MASK_W:0]     lock_inc;
	logic [dotrig_pkg::MASK_W-1:0]   lock_base, lockout_count_d;
	logic                            lockout_active_d, fire_d, run_cond;

	always_comb begin
		abs_val = scaled_s2[dotrig_pkg::SCALED_W-1] ? (~scaled_s2 + 1'b1) : scaled_s2;
		mag     = abs_val[LVL_W-1:0];

		window_max = (mag > window_peak_q) ? mag : window_peak_q;
		envelope_d = envelope_q;
		if (window_count_q == WC_LAST) begin
			envelope_d     = window_max;
			window_peak_d  = '0;
			window_count_d = '0;
		end else begin
			window_peak_d  = window_max;
			window_count_d = window_count_q + 1'b1;
		end

		run_cond         = {{(LVL_W - dotrig_pkg::THR_W){1'b0}}, thr_q} < envelope_d;
		run_max          = (mag > run_peak_q) ? mag : run_peak_q;
		run_inc          = {1'b0, run_count_q} + 1'b1;
		run_peak_d       = run_peak_q;
		run_count_d      = '0;
		held_d           = held_q;
		lockout_active_d = lockout_active_q;
		lock_base        = lockout_count_q;
		fire_d           = 1'b0;
		if (run_cond) begin
			if (run_inc >= {1'b0, offset_q}) begin
				held_d     = run_max;
				run_peak_d = '0;
				if ((lockout_count_q < mask_q) && !lockout_active_q) begin
					lockout_active_d = 1'b1;
					fire_d           = enable_q;
					lock_base        = '0;
				end
			end else begin
				run_peak_d  = run_max;
				run_count_d = run_inc[dotrig_pkg::OFFSET_W-1:0];
			end
		end

		lock_inc = {1'b0, lock_base} + 1'b1;
		if (lock_inc >= {1'b0, mask_q}) begin
			lockout_active_d = 1'b0;
			lockout_count_d  = '0;
		end else begin
			lockout_count_d = lock_inc[dotrig_pkg::MASK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_peak_q    <= '0;
			window_count_q   <= '0;
			envelope_q       <= '0;
			run_peak_q       <= '0;
			run_count_q      <= '0;
			held_q           <= '0;
			lockout_count_q  <= '0;
			lockout_active_q <= 1'b0;
		end else if (upd) begin
			window_peak_q    <= window_peak_d;
			window_count_q   <= window_count_d;
			envelope_q       <= envelope_d;
			run_peak_q       <= run_peak_d;
			run_count_q      <= run_count_d;
			held_q           <= held_d;
			lockout_count_q  <= lockout_count_d;
			lockout_active_q <= lockout_active_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (upd) begin
			scaled_sample <= scaled_s2;
			trigger_fire  <= fire_d;
			trigger_level <= held_d;
		end
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> s1_valid_q)
		else $error("accepted item did not enter the input stage");

	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> out_valid_q)
		else $error("state update did not produce a result");

	a_window_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		window_count_q <= WC_LAST)
		else $error("window counter passed the window length");

	a_run_cleared_below: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !run_cond |=> run_count_q == '0)
		else $error("run counter not cleared below threshold");

endmodule
